>>> rtl/lfpd_pkg.sv
// Shared types, constants and the sensor decoder for the line-follower PID drive.
// No dependencies; imported by line_follow_pid_drive_top.
package lfpd_pkg;

  localparam int SUM_WIDTH  = 16;
  localparam int ERR_W      = 4;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int GAIN_W     = 8;
  localparam int CORR_W     = 25;
  localparam int DUTY_W     = 8;
  localparam int SENSOR_W   = 7;
  localparam int CALC_W     = (SUM_WIDTH + 11 > CORR_W + 1) ? SUM_WIDTH + 11 : CORR_W + 1;
  localparam int DUTY_CALC_W = CORR_W + 2;

  localparam int CORR_LIMIT = 8400000;
  localparam int DUTY_MAX   = 255;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd80;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 8'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 8'd30;
  localparam logic [DUTY_W-1:0] BASE_SPEED_RST = 8'd200;

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_BASE_SPEED = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    STEER_FWD   = 2'd0,
    STEER_LEFT  = 2'd1,
    STEER_RIGHT = 2'd2
  } steer_t;

  typedef struct packed {
    logic                    hit;
    logic signed [ERR_W-1:0] err;
  } decode_t;

  function automatic decode_t decode_position(input logic [SENSOR_W-1:0] bits);
    decode_t d;
    d.hit = 1'b1;
    d.err = '0;
    case (bits)
      7'h40: d.err = 4'sd6;
      7'h20: d.err = 4'sd5;
      7'h10: d.err = 4'sd4;
      7'h18: d.err = 4'sd3;
      7'h30: d.err = 4'sd2;
      7'h60: d.err = 4'sd1;
      7'h08: d.err = 4'sd0;
      7'h0C: d.err = -4'sd1;
      7'h06: d.err = -4'sd2;
      7'h03: d.err = -4'sd3;
      7'h04: d.err = -4'sd4;
      7'h02: d.err = -4'sd5;
      7'h01: d.err = -4'sd6;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/line_follow_pid_drive_top.sv
// Top level of the line-follower PID drive: sensor decode, integral, PID sum and
// motor duty clamp. Depends on lfpd_pkg.
//
// One sensor sample is accepted per cycle while the input ready is high. Its result
// is held in the stage 1 registers and loaded into the output register once that
// register is free. The first stage decodes the sample and updates the held
// error and the saturating integral; the second stage forms the three gain products,
// their clamped sum, both clamped duties and the steering direction. Gain and speed
// registers should only be written while no request is in flight. The input ready
// depends on the output ready through the two stages.
module line_follow_pid_drive_top
  import lfpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,     // [6:0] sensor_bits, [7] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,    // [3:0] position_error, [28:4] correction,
                                              // [36:29] left_duty, [44:37] right_duty,
                                              // [46:45] steer_dir, [47] zero
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [DUTY_W-1:0] base_speed_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      base_speed_r <= BASE_SPEED_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_r <= cfg_pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_r <= cfg_pwdata[GAIN_W-1:0];
        REG_BASE_SPEED: base_speed_r <= cfg_pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_PROP_GAIN:  cfg_prdata = CFG_DATA_W'(prop_gain_r);
      REG_INTEG_GAIN: cfg_prdata = CFG_DATA_W'(integ_gain_r);
      REG_DERIV_GAIN: cfg_prdata = CFG_DATA_W'(deriv_gain_r);
      REG_BASE_SPEED: cfg_prdata = CFG_DATA_W'(base_speed_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Handshake between the two stages.
  logic s1_valid_r, out_valid_r;
  logic out_free, s1_move, in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Stage 1: decode and state update.
  logic signed [ERR_W-1:0]     held_error_r;
  logic signed [SUM_WIDTH-1:0] error_sum_r;
  decode_t                     dec;
  logic signed [ERR_W-1:0]     err_nxt;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_nxt;
  logic signed [DIFF_W-1:0]    diff_nxt;

  assign dec      = decode_position(in_tdata[SENSOR_W-1:0]);
  assign err_nxt  = dec.hit ? dec.err : held_error_r;
  assign sum_wide = (SUM_WIDTH+1)'(error_sum_r) + (SUM_WIDTH+1)'(err_nxt);
  assign diff_nxt = DIFF_W'(err_nxt) - DIFF_W'(held_error_r);

  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_nxt = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[SUM_WIDTH-1:0];
    end
  end

  logic signed [ERR_W-1:0]     s1_err_r;
  logic signed [SUM_WIDTH-1:0] s1_sum_r;
  logic signed [DIFF_W-1:0]    s1_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      held_error_r <= '0;
      error_sum_r  <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r   <= 1'b1;
        held_error_r <= err_nxt;
        error_sum_r  <= sum_nxt;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err_r  <= err_nxt;
      s1_sum_r  <= sum_nxt;
      s1_diff_r <= diff_nxt;
    end
  end

  // Stage 2: PID sum, clamp and duties.
  logic signed [CALC_W-1:0]      p_term, i_term, d_term, corr_full;
  logic signed [CORR_W-1:0]      corr_nxt;
  logic signed [DUTY_CALC_W-1:0] base_ext, left_full, right_full;
  logic [DUTY_W-1:0]             left_nxt, right_nxt;
  steer_t                        steer_nxt;

  assign p_term = $signed(CALC_W'({1'b0, prop_gain_r}))  * CALC_W'(s1_err_r);
  assign i_term = $signed(CALC_W'({1'b0, integ_gain_r})) * CALC_W'(s1_sum_r);
  assign d_term = $signed(CALC_W'({1'b0, deriv_gain_r})) * CALC_W'(s1_diff_r);
  assign corr_full = p_term + i_term + d_term;

  always_comb begin
    if (corr_full > CALC_W'(CORR_LIMIT)) begin
      corr_nxt = CORR_W'(CORR_LIMIT);
    end else if (corr_full < -CALC_W'(CORR_LIMIT)) begin
      corr_nxt = -CORR_W'(CORR_LIMIT);
    end else begin
      corr_nxt = corr_full[CORR_W-1:0];
    end
  end

  assign base_ext   = $signed(DUTY_CALC_W'({1'b0, base_speed_r}));
  assign left_full  = base_ext - DUTY_CALC_W'(corr_nxt);
  assign right_full = base_ext + DUTY_CALC_W'(corr_nxt);

  always_comb begin
    if (left_full < 0) begin
      left_nxt = '0;
    end else if (left_full > DUTY_CALC_W'(DUTY_MAX)) begin
      left_nxt = DUTY_W'(DUTY_MAX);
    end else begin
      left_nxt = left_full[DUTY_W-1:0];
    end
    if (right_full < 0) begin
      right_nxt = '0;
    end else if (right_full > DUTY_CALC_W'(DUTY_MAX)) begin
      right_nxt = DUTY_W'(DUTY_MAX);
    end else begin
      right_nxt = right_full[DUTY_W-1:0];
    end
    if (s1_err_r == 0) begin
      steer_nxt = STEER_FWD;
    end else if (s1_err_r > 0) begin
      steer_nxt = STEER_LEFT;
    end else begin
      steer_nxt = STEER_RIGHT;
    end
  end

  logic signed [ERR_W-1:0]  out_err_r;
  logic signed [CORR_W-1:0] out_corr_r;
  logic [DUTY_W-1:0]        out_left_r, out_right_r;
  steer_t                   out_steer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_err_r   <= s1_err_r;
      out_corr_r  <= corr_nxt;
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_steer_r <= steer_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_steer_r, out_right_r, out_left_r, out_corr_r, out_err_r};

endmodule

>>> tb/sv/line_follow_pid_drive_top_tb.sv
// Self-checking testbench for line_follow_pid_drive_top: sensor requests, gain setup
// over the APB-style port, and a field-by-field check of every drive result.
// Depends on lfpd_pkg and the top-level RTL only.
module line_follow_pid_drive_top_tb;
  import lfpd_pkg::*;

  localparam longint SUM_MAX = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic signed [ERR_W-1:0]  err;
    logic signed [CORR_W-1:0] corr;
    logic [DUTY_W-1:0]        left;
    logic [DUTY_W-1:0]        right;
    steer_t                   dir;
  } drive_result_t;

  class drive_scoreboard;
    int                held_err;
    longint            err_sum;
    logic [GAIN_W-1:0] kp, ki, kd;
    logic [DUTY_W-1:0] base;
    logic [SENSOR_W-1:0] pattern_of [13];
    drive_result_t     expected_q [$];
    int                bad_count;

    function new();
      pattern_of = '{7'h01, 7'h02, 7'h04, 7'h03, 7'h06, 7'h0C, 7'h08,
                     7'h60, 7'h30, 7'h18, 7'h10, 7'h20, 7'h40};
      kp = PROP_GAIN_RST;
      ki = INTEG_GAIN_RST;
      kd = DERIV_GAIN_RST;
      base = BASE_SPEED_RST;
      held_err = 0;
      err_sum = 0;
      bad_count = 0;
    endfunction

    function bit lookup(input logic [SENSOR_W-1:0] bits, inout int e);
      for (int i = 0; i < 13; i++) begin
        if (bits == pattern_of[i]) begin
          e = i - 6;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void set_reg(input reg_idx_t idx, input logic [7:0] value);
      case (idx)
        REG_PROP_GAIN:  kp = value;
        REG_INTEG_GAIN: ki = value;
        REG_DERIV_GAIN: kd = value;
        REG_BASE_SPEED: base = value;
        default: ;
      endcase
    endfunction

    function longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_sample(input logic [SENSOR_W-1:0] bits);
      int e;
      longint c;
      drive_result_t want;
      e = held_err;
      void'(lookup(bits, e));
      err_sum = clip(err_sum + e, SUM_MIN, SUM_MAX);
      c = longint'(kp) * e + longint'(ki) * err_sum + longint'(kd) * (e - held_err);
      c = clip(c, -CORR_LIMIT, CORR_LIMIT);
      held_err = e;
      want.err = ERR_W'(e);
      want.corr = CORR_W'(c);
      want.left = DUTY_W'(clip(longint'(base) - c, 0, DUTY_MAX));
      want.right = DUTY_W'(clip(longint'(base) + c, 0, DUTY_MAX));
      want.dir = (e == 0) ? STEER_FWD : ((e > 0) ? STEER_LEFT : STEER_RIGHT);
      expected_q.push_back(want);
    endfunction

    function void complain(input string msg);
      bad_count++;
      if (bad_count <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(input logic [47:0] word);
      drive_result_t got, want;
      got.err = word[3:0];
      got.corr = word[28:4];
      got.left = word[36:29];
      got.right = word[44:37];
      got.dir = steer_t'(word[46:45]);
      if (expected_q.size() == 0) begin
        complain($sformatf("drive result 0x%012h with no request pending", word));
        return;
      end
      want = expected_q.pop_front();
      if (got.err !== want.err)
        complain($sformatf("position_error expected %0d, got %0d", want.err, got.err));
      if (got.corr !== want.corr)
        complain($sformatf("correction expected %0d, got %0d", want.corr, got.corr));
      if (got.left !== want.left)
        complain($sformatf("left_duty expected %0d, got %0d", want.left, got.left));
      if (got.right !== want.right)
        complain($sformatf("right_duty expected %0d, got %0d", want.right, got.right));
      if (got.dir !== want.dir)
        complain($sformatf("steer_dir expected %0d, got %0d", want.dir, got.dir));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;     // [6:0] sensor_bits, [7] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [47:0]           out_tdata;         // [3:0] position_error, [28:4] correction,
                                            // [36:29] left_duty, [44:37] right_duty,
                                            // [46:45] steer_dir, [47] zero
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  drive_scoreboard sb = new();
  bit              steady = 1'b0;
  int              cycles = 0;

  line_follow_pid_drive_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("line_follow_pid_drive_top regression: fail");
      $finish;
    end
  end

  task automatic send_sample(input logic [SENSOR_W-1:0] bits);
    while (!steady && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, bits};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(bits);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {junk[CFG_DATA_W-1:8], value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_gains(input logic [7:0] kp, input logic [7:0] ki,
                           input logic [7:0] kd, input logic [7:0] base);
    wait_drain();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_BASE_SPEED, base);
  endtask

  function automatic logic [SENSOR_W-1:0] random_sample();
    if ($urandom_range(99) < 75) return sb.pattern_of[$urandom_range(12)];
    return SENSOR_W'($urandom_range(127));
  endfunction

  task automatic run_phase(input logic [7:0] kp, input logic [7:0] ki,
                           input logic [7:0] kd, input logic [7:0] base,
                           input int count, input bit calm, input int pause_at);
    set_gains(kp, ki, kd, base);
    steady = calm;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_drain();
      send_sample(random_sample());
    end
    steady = 1'b0;
  endtask

  initial begin
    logic [SENSOR_W-1:0] directed_q [$];
    directed_q = '{7'h08, 7'h00, 7'h40, 7'h7F, 7'h01, 7'h20, 7'h02, 7'h10, 7'h04,
                   7'h18, 7'h03, 7'h30, 7'h06, 7'h60, 7'h0C, 7'h55, 7'h2A, 7'h08};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_q[i]) send_sample(directed_q[i]);

    run_phase(8'd0, 8'd0, 8'd0, 8'd0, 150, 1'b0, -1);
    run_phase(8'd255, 8'd255, 8'd255, 8'd255, 250, 1'b0, 120);
    run_phase(8'($urandom()), 8'($urandom_range(3)), 8'($urandom()), 8'($urandom()),
              250, 1'b1, -1);
    run_phase(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
              250, 1'b0, -1);
    run_phase(8'd255, 8'd0, 8'd255, 8'd128, 200, 1'b0, -1);
    run_phase(8'($urandom_range(40)), 8'd1, 8'($urandom_range(40)), 8'd255,
              250, 1'b0, -1);
    run_phase(8'($urandom()), 8'($urandom_range(16)), 8'($urandom()), 8'($urandom()),
              250, 1'b0, 60);
    run_phase(8'd0, 8'd255, 8'd0, 8'd0, 150, 1'b0, -1);

    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.bad_count == 0 && sb.pending() == 0) begin
      $display("line_follow_pid_drive_top regression: pass");
    end else begin
      $display("line_follow_pid_drive_top regression: fail");
    end
    $finish;
  end

endmodule
